/* sv/krdt_pkg.sv */
// ----------------------------------------------------------------------------
// krdt_pkg
// Shared types and constants for the keyed record diff table: the entry
// layout, the cell control bundle, the command, side and status codes.
// ----------------------------------------------------------------------------
package krdt_pkg;

   // table size and reduction tree shape
   localparam int CAPACITY    = 256;
   localparam int GROUP_SIZE  = 16;
   localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_SIZE    = NUM_GROUPS * GROUP_SIZE;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   typedef enum logic {
      CMD_RECORD = 1'b0,
      CMD_DRAIN  = 1'b1
   } cmd_type;

   typedef enum logic {
      SIDE_A = 1'b0,
      SIDE_B = 1'b1
   } side_type;

   typedef enum logic [1:0] {
      STATUS_MISMATCH = 2'd0,
      STATUS_LEFTOVER = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_SHIFT  = 2'd3
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_GATHER = 2'd1,
      ST_APPLY  = 2'd2
   } state_type;

   // one stored record
   typedef struct packed {
      logic [15:0] file;
      logic [63:0] offset;
      logic [63:0] length;
      logic [63:0] hash;
      side_type    side;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      logic        capture;
      cell_op_type op;
      logic [15:0] file;
      logic [63:0] offset;
   } cell_ctrl_type;

endpackage

/* sv/krdt_cell.sv */
// ----------------------------------------------------------------------------
// krdt_cell
// One slot of the sorted entry chain. Holds an entry, compares it against the
// key of an arriving transaction and moves entries to or from its neighbors.
// ----------------------------------------------------------------------------
module krdt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  krdt_pkg::cell_ctrl_type ctrl,
   input  krdt_pkg::entry_type    new_entry,
   input  krdt_pkg::entry_type    left_entry,
   input  logic                   left_valid,
   input  logic                   left_gt,
   input  krdt_pkg::entry_type    right_entry,
   input  logic                   right_valid,
   output krdt_pkg::entry_type    entry,
   output logic                   valid,
   output logic                   gt,
   output logic                   hit
);
   import krdt_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      gt_ff, gt_in;
   logic      hit_ff, hit_in;

   // key compare flags, taken when a record transaction is accepted
   always_comb begin
      gt_in  = gt_ff;
      hit_in = hit_ff;
      if (ctrl.capture) begin
         hit_in = valid_ff && (entry_ff.file == ctrl.file) && (entry_ff.offset == ctrl.offset);
         gt_in  = !valid_ff ||
                  ({entry_ff.file, entry_ff.offset} > {ctrl.file, ctrl.offset});
      end
   end

   // neighbor moves keep the chain sorted and packed toward slot zero
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (left_gt) begin
               entry_in = left_entry;
               valid_in = left_valid;
            end else if (gt_ff) begin
               entry_in = new_entry;
               valid_in = 1'b1;
            end
         end
         OP_DELETE: begin
            if (gt_ff || hit_ff) begin
               entry_in = right_entry;
               valid_in = right_valid;
            end
         end
         OP_SHIFT: begin
            entry_in = right_entry;
            valid_in = right_valid;
         end
         default: begin
            entry_in = entry_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         gt_ff    <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         gt_ff    <= gt_in;
         hit_ff   <= hit_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign gt    = gt_ff;
   assign hit   = hit_ff;

endmodule

/* sv/krdt_chain.sv */
// ----------------------------------------------------------------------------
// krdt_chain
// Row of table cells kept in ascending key order, plus the first registered
// level of the tree that collects the stored hash of the matching cell.
// ----------------------------------------------------------------------------
module krdt_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  krdt_pkg::cell_ctrl_type ctrl,
   input  krdt_pkg::entry_type     new_entry,
   input  logic                    gather_en,
   output krdt_pkg::entry_type     head_entry,
   output logic                    head_valid,
   output logic [krdt_pkg::NUM_GROUPS-1:0] group_hit,
   output logic [63:0]             group_hash [krdt_pkg::NUM_GROUPS]
);
   import krdt_pkg::*;

   entry_type             entry_w [CAPACITY];
   logic [CAPACITY-1:0]   valid_w;
   logic [CAPACITY-1:0]   gt_w;
   logic [CAPACITY-1:0]   hit_w;

   logic [PAD_SIZE-1:0]   hit_pad;
   logic [63:0]           hash_pad [PAD_SIZE];

   logic [NUM_GROUPS-1:0] group_hit_ff, group_hit_in;
   logic [63:0]           group_hash_ff [NUM_GROUPS];
   logic [63:0]           group_hash_in [NUM_GROUPS];

   // cell row, each wired to its two neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_valid, left_gt, right_valid;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_valid = 1'b0;
         assign left_gt    = 1'b0;
      end else begin : g_mid_left
         assign left_entry = entry_w[i-1];
         assign left_valid = valid_w[i-1];
         assign left_gt    = gt_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid_right
         assign right_entry = entry_w[i+1];
         assign right_valid = valid_w[i+1];
      end

      krdt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .entry       (entry_w[i]),
         .valid       (valid_w[i]),
         .gt          (gt_w[i]),
         .hit         (hit_w[i])
      );
   end

   // pad the hit row out to whole groups
   for (genvar i = 0; i < PAD_SIZE; i++) begin : g_pad
      if (i < CAPACITY) begin : g_real
         assign hit_pad[i]  = hit_w[i];
         assign hash_pad[i] = entry_w[i].hash;
      end else begin : g_fill
         assign hit_pad[i]  = 1'b0;
         assign hash_pad[i] = '0;
      end
   end

   // per-group or of the matching hash
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_hit_in[g]  = 1'b0;
         group_hash_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            group_hit_in[g]  = group_hit_in[g] | hit_pad[g*GROUP_SIZE + j];
            group_hash_in[g] = group_hash_in[g] |
                               (hash_pad[g*GROUP_SIZE + j] & {64{hit_pad[g*GROUP_SIZE + j]}});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_hit_ff <= '0;
      end else if (gather_en) begin
         group_hit_ff <= group_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (gather_en) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_hash_ff[g] <= group_hash_in[g];
         end
      end
   end

   assign head_entry = entry_w[0];
   assign head_valid = valid_w[0];
   assign group_hit  = group_hit_ff;
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_out
      assign group_hash[g] = group_hash_ff[g];
   end

endmodule

/* sv/keyed_record_diff_table_unit.sv */
// ----------------------------------------------------------------------------
// keyed_record_diff_table_unit
// Matches records of two streams by (file, offset) key in a sorted chain of
// cells and reports hash mismatches, dropped records and drained leftovers.
// ----------------------------------------------------------------------------
// order: a record passes the gather state, then the apply state, which loads
//    the result register when it reports; a drain goes straight to apply
// flow: one transaction at a time; a new request is stalled until the apply
//    step ends, and apply itself waits while a held result is stalled
// reset: synchronous, clears all cell valid bits and the fill count, so the
//    table is empty as soon as reset ends, with no clearing pass
module keyed_record_diff_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic        req_side,
   input  logic [15:0] req_file_id,
   input  logic [63:0] req_offset,
   input  logic [63:0] req_length,
   input  logic [63:0] req_digest,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_file_id,
   output logic [63:0] rsp_out_offset,
   output logic [63:0] rsp_out_length,
   output logic [63:0] rsp_hash_a,
   output logic [63:0] rsp_hash_b,
   output logic        rsp_last_leftover
);
   import krdt_pkg::*;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   cmd_type                op_cmd_ff;
   entry_type              op_entry_ff;

   logic                   req_accept;
   logic                   out_free;
   logic                   apply_go;
   cell_ctrl_type          ctrl;
   cell_op_type            cell_op;
   entry_type              head_entry;
   logic                   head_valid;
   logic [NUM_GROUPS-1:0]  group_hit;
   logic [63:0]            group_hash [NUM_GROUPS];
   logic                   table_hit;
   logic [63:0]            stored_hash;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   load_rsp;
   status_type             rsp_status_ff, rsp_status_in;
   logic [15:0]            rsp_file_ff, rsp_file_in;
   logic [63:0]            rsp_offset_ff, rsp_offset_in;
   logic [63:0]            rsp_length_ff, rsp_length_in;
   logic [63:0]            rsp_hash_a_ff, rsp_hash_a_in;
   logic [63:0]            rsp_hash_b_ff, rsp_hash_b_in;
   logic                   rsp_last_ff, rsp_last_in;

   // handshake
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign apply_go   = (state_ff == ST_APPLY) && out_free;

   // capture the transaction
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_cmd_ff          <= cmd_type'(req_cmd);
         op_entry_ff.file   <= req_file_id;
         op_entry_ff.offset <= req_offset;
         op_entry_ff.length <= req_length;
         op_entry_ff.hash   <= req_digest;
         op_entry_ff.side   <= side_type'(req_side);
      end
   end

   // cell row
   assign ctrl.capture = req_accept && (req_cmd == CMD_RECORD);
   assign ctrl.op      = cell_op;
   assign ctrl.file    = req_file_id;
   assign ctrl.offset  = req_offset;

   krdt_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .new_entry  (op_entry_ff),
      .gather_en  (state_ff == ST_GATHER),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .group_hit  (group_hit),
      .group_hash (group_hash)
   );

   // last level of the hash gather
   always_comb begin
      stored_hash = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         stored_hash = stored_hash | group_hash[g];
      end
   end
   assign table_hit = |group_hit;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_cmd == CMD_DRAIN) ? ST_APPLY : ST_GATHER;
            end
         end
         ST_GATHER: state_in = ST_APPLY;
         ST_APPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // apply step: table update, fill count and result
   always_comb begin
      cell_op       = OP_HOLD;
      count_in      = count_ff;
      load_rsp      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_file_in   = rsp_file_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_length_in = rsp_length_ff;
      rsp_hash_a_in = rsp_hash_a_ff;
      rsp_hash_b_in = rsp_hash_b_ff;
      rsp_last_in   = rsp_last_ff;
      if (apply_go) begin
         if (op_cmd_ff == CMD_RECORD) begin
            rsp_file_in   = op_entry_ff.file;
            rsp_offset_in = op_entry_ff.offset;
            rsp_length_in = op_entry_ff.length;
            rsp_last_in   = 1'b0;
            if (table_hit) begin
               cell_op  = OP_DELETE;
               count_in = count_ff - COUNT_WIDTH'(1);
               if (stored_hash != op_entry_ff.hash) begin
                  load_rsp      = 1'b1;
                  rsp_status_in = STATUS_MISMATCH;
                  rsp_hash_a_in = (op_entry_ff.side == SIDE_A) ? op_entry_ff.hash : stored_hash;
                  rsp_hash_b_in = (op_entry_ff.side == SIDE_B) ? op_entry_ff.hash : stored_hash;
               end
            end else if (count_ff == COUNT_WIDTH'(CAPACITY)) begin
               load_rsp      = 1'b1;
               rsp_status_in = STATUS_FULL;
               rsp_hash_a_in = (op_entry_ff.side == SIDE_A) ? op_entry_ff.hash : '0;
               rsp_hash_b_in = (op_entry_ff.side == SIDE_B) ? op_entry_ff.hash : '0;
            end else begin
               cell_op  = OP_INSERT;
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end else if (count_ff != '0) begin
            // drain the smallest key from the head cell
            cell_op       = OP_SHIFT;
            count_in      = count_ff - COUNT_WIDTH'(1);
            load_rsp      = 1'b1;
            rsp_status_in = STATUS_LEFTOVER;
            rsp_file_in   = head_entry.file;
            rsp_offset_in = head_entry.offset;
            rsp_length_in = head_entry.length;
            rsp_hash_a_in = (head_entry.side == SIDE_A) ? head_entry.hash : '0;
            rsp_hash_b_in = (head_entry.side == SIDE_B) ? head_entry.hash : '0;
            rsp_last_in   = (count_ff == COUNT_WIDTH'(1));
         end
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_file_ff   <= rsp_file_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_length_ff <= rsp_length_in;
         rsp_hash_a_ff <= rsp_hash_a_in;
         rsp_hash_b_ff <= rsp_hash_b_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_file_id   = rsp_file_ff;
   assign rsp_out_offset    = rsp_offset_ff;
   assign rsp_out_length    = rsp_length_ff;
   assign rsp_hash_a        = rsp_hash_a_ff;
   assign rsp_hash_b        = rsp_hash_b_ff;
   assign rsp_last_leftover = rsp_last_ff;

   // fill count never passes the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(CAPACITY))
      else $error("fill count above capacity");

   // head cell holds an entry exactly when the table is not empty
   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      head_valid == (count_ff != '0))
      else $error("head cell valid disagrees with fill count");

   // a key is matched in at most one cell group
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(group_hit))
      else $error("key matched in more than one group");

   // a drain of a non-empty table always produces a result
   a_drain_result: assert property (@(posedge clock) disable iff (reset)
      (apply_go && (op_cmd_ff == CMD_DRAIN) && (count_ff != '0)) |=> rsp_valid_ff)
      else $error("drain of non-empty table gave no result");

endmodule

/* test/keyed_record_diff_table_unit_test.sv */
// ----------------------------------------------------------------------------
// keyed_record_diff_table_unit_test
// Self-checking bench for the keyed record diff table. Record and drain
// transactions go in with random bursts and gaps, while the result side
// stalls in changing patterns. A scoreboard table inside the bench tracks
// the held entries, predicts each mismatch, drop and leftover report, and
// checks them in order against the result channel.
// ----------------------------------------------------------------------------
module keyed_record_diff_table_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import krdt_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_LIMIT = 2000;
   localparam int TAIL_CYCLES  = 12;
   localparam int REPORT_LIMIT = 10;
   localparam int POOL_MAX     = 32;

   // one result transaction
   typedef struct packed {
      status_type  status;
      logic [15:0] file;
      logic [63:0] offset;
      logic [63:0] length;
      logic [63:0] hash_a;
      logic [63:0] hash_b;
      logic        last;
   } diff_report_type;

   typedef enum {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_RUNS
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cmd_type     req_cmd = CMD_RECORD;
   side_type    req_side = SIDE_A;
   logic [15:0] req_file_id = '0;
   logic [63:0] req_offset = '0;
   logic [63:0] req_length = '0;
   logic [63:0] req_digest = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_file_id;
   logic [63:0] rsp_out_offset;
   logic [63:0] rsp_out_length;
   logic [63:0] rsp_hash_a;
   logic [63:0] rsp_hash_b;
   logic        rsp_last_leftover;

   // scoreboard copy of the table
   logic        held_valid  [CAPACITY];
   logic [15:0] held_file   [CAPACITY];
   logic [63:0] held_offset [CAPACITY];
   logic [63:0] held_length [CAPACITY];
   logic [63:0] held_hash   [CAPACITY];
   side_type    held_side   [CAPACITY];

   diff_report_type pending_reports[$];
   int              mismatch_count = 0;
   int              burst_left = 0;

   keyed_record_diff_table_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_side          (req_side),
      .req_file_id       (req_file_id),
      .req_offset        (req_offset),
      .req_length        (req_length),
      .req_digest        (req_digest),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_file_id   (rsp_out_file_id),
      .rsp_out_offset    (rsp_out_offset),
      .rsp_out_length    (rsp_out_length),
      .rsp_hash_a        (rsp_hash_a),
      .rsp_hash_b        (rsp_hash_b),
      .rsp_last_leftover (rsp_last_leftover)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // random field values, extremes favored
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] pick_file();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_offset();
      case ($urandom_range(0, 9))
         0: return 64'h0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         default: return rand64();
      endcase
   endfunction

   function automatic side_type pick_side();
      return side_type'($urandom_range(0, 1));
   endfunction

   function automatic int table_fill();
      int n;
      n = 0;
      for (int i = 0; i < CAPACITY; i++)
         if (held_valid[i]) n++;
      return n;
   endfunction

   // append one expected result at the tail
   function automatic void queue_report(diff_report_type rep);
      pending_reports = {pending_reports, rep};
   endfunction

   // update the scoreboard table and queue the report this transaction causes
   function automatic void predict_report(cmd_type cmd, side_type side, logic [15:0] file,
                                          logic [63:0] offset, logic [63:0] length,
                                          logic [63:0] digest);
      int              free_slot;
      int              best;
      int              count;
      diff_report_type rep;
      free_slot = -1;
      best = -1;
      count = 0;
      rep = '0;
      if (cmd == CMD_RECORD) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (held_valid[i]) begin
               if (held_file[i] == file && held_offset[i] == offset) begin
                  // hit: entry leaves, report only on differing hashes
                  held_valid[i] = 1'b0;
                  if (held_hash[i] != digest) begin
                     rep.status = STATUS_MISMATCH;
                     rep.file   = file;
                     rep.offset = offset;
                     rep.length = length;
                     rep.hash_a = (side == SIDE_A) ? digest : held_hash[i];
                     rep.hash_b = (side == SIDE_B) ? digest : held_hash[i];
                     queue_report(rep);
                  end
                  return;
               end
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (free_slot < 0) begin
            // no room: record dropped
            rep.status = STATUS_FULL;
            rep.file   = file;
            rep.offset = offset;
            rep.length = length;
            rep.hash_a = (side == SIDE_A) ? digest : 64'h0;
            rep.hash_b = (side == SIDE_B) ? digest : 64'h0;
            queue_report(rep);
         end else begin
            held_valid[free_slot]  = 1'b1;
            held_file[free_slot]   = file;
            held_offset[free_slot] = offset;
            held_length[free_slot] = length;
            held_hash[free_slot]   = digest;
            held_side[free_slot]   = side;
         end
      end else begin
         // drain: smallest key goes out
         for (int i = 0; i < CAPACITY; i++) begin
            if (held_valid[i]) begin
               count++;
               if (best < 0 || {held_file[i], held_offset[i]} <
                               {held_file[best], held_offset[best]})
                  best = i;
            end
         end
         if (best >= 0) begin
            held_valid[best] = 1'b0;
            rep.status = STATUS_LEFTOVER;
            rep.file   = held_file[best];
            rep.offset = held_offset[best];
            rep.length = held_length[best];
            rep.hash_a = (held_side[best] == SIDE_A) ? held_hash[best] : 64'h0;
            rep.hash_b = (held_side[best] == SIDE_B) ? held_hash[best] : 64'h0;
            rep.last   = (count == 1);
            queue_report(rep);
         end
      end
   endfunction

   // drive one transaction in bursts with random gaps, predict on acceptance
   task automatic send_item(cmd_type cmd, side_type side, logic [15:0] file,
                            logic [63:0] offset, logic [63:0] length, logic [63:0] digest);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            req_valid   = 1'b0;
            req_cmd     = cmd_type'($urandom_range(0, 1));
            req_side    = pick_side();
            req_file_id = 16'($urandom);
            req_offset  = rand64();
            req_length  = rand64();
            req_digest  = rand64();
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   = 1'b1;
      req_cmd     = cmd;
      req_side    = side;
      req_file_id = file;
      req_offset  = offset;
      req_length  = length;
      req_digest  = digest;
      do @(posedge clock); while (req_stall);
      predict_report(cmd, side, file, offset, length, digest);
   endtask

   task automatic send_record(side_type side, logic [15:0] file, logic [63:0] offset,
                              logic [63:0] length, logic [63:0] digest);
      send_item(CMD_RECORD, side, file, offset, length, digest);
   endtask

   // key, length, digest and side carry junk on a drain
   task automatic send_drain();
      send_item(CMD_DRAIN, pick_side(), 16'($urandom), rand64(), rand64(), rand64());
   endtask

   task automatic drain_all();
      while (table_fill() != 0) send_drain();
      send_drain();
   endtask

   task automatic fill_table(int target);
      while (table_fill() < target)
         send_record(pick_side(), pick_file(), pick_offset(), rand64(), rand64());
   endtask

   // pool keys come back from either side, mostly with the same digest
   task automatic run_mixed_traffic(int count, int pool_size, int fresh_pct, int drain_pct);
      logic [15:0] pool_file   [POOL_MAX];
      logic [63:0] pool_offset [POOL_MAX];
      logic [63:0] pool_digest [POOL_MAX];
      int          k;
      int          roll;
      for (int i = 0; i < pool_size; i++) begin
         pool_file[i]   = pick_file();
         pool_offset[i] = pick_offset();
         pool_digest[i] = rand64();
      end
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < drain_pct) begin
            send_drain();
         end else if (roll < drain_pct + fresh_pct) begin
            send_record(pick_side(), pick_file(), pick_offset(), rand64(), rand64());
         end else begin
            k = $urandom_range(0, pool_size - 1);
            send_record(pick_side(), pool_file[k], pool_offset[k], pick_offset(),
                        ($urandom_range(0, 3) != 0) ? pool_digest[k] : rand64());
         end
      end
      drain_all();
   endtask

   // extremes, hit kinds from both sides, ordered drain
   task automatic test_directed_cases();
      send_drain();
      send_record(SIDE_A, 16'h0000, 64'h0, 64'h0, 64'h0);
      send_record(SIDE_B, 16'h0000, 64'h0, '1, 64'h0);
      send_record(SIDE_A, 16'hFFFF, '1, '1, '1);
      send_record(SIDE_B, 16'hFFFF, '1, 64'h0, 64'h0);
      // same side with different then equal digests
      send_record(SIDE_A, 16'h1234, 64'h5, 64'h40, 64'hAAAA_AAAA_AAAA_AAAA);
      send_record(SIDE_A, 16'h1234, 64'h5, 64'h80, 64'h5555_5555_5555_5555);
      send_record(SIDE_B, 16'h0001, 64'h8000_0000_0000_0000, 64'h10, 64'h77);
      send_record(SIDE_B, 16'h0001, 64'h8000_0000_0000_0000, 64'h20, 64'h77);
      send_record(SIDE_B, 16'h00FF, 64'hDEAD_BEEF, 64'h1000, 64'h1);
      send_record(SIDE_A, 16'h00FF, 64'hDEAD_BEEF, 64'h2000, 64'h2);
      // leftovers in scrambled key order
      send_record(SIDE_A, 16'h0007, 64'd100, 64'h11, 64'hA1);
      send_record(SIDE_B, 16'h0007, 64'd3, 64'h22, 64'hB2);
      send_record(SIDE_A, 16'h0002, '1, 64'h33, 64'hA3);
      send_record(SIDE_B, 16'hFFFF, 64'h0, 64'h44, 64'hB4);
      send_record(SIDE_A, 16'h0007, 64'h8000_0000_0000_0000, 64'h55, 64'hA5);
      drain_all();
   endtask

   // drops on a full table, hits still work while full
   task automatic test_full_table();
      logic [15:0] kept_file;
      logic [63:0] kept_offset;
      logic [63:0] kept_hash;
      fill_table(CAPACITY);
      kept_file   = held_file[0];
      kept_offset = held_offset[0];
      kept_hash   = held_hash[0];
      send_record(SIDE_A, pick_file(), rand64(), rand64(), rand64());
      send_record(SIDE_B, pick_file(), rand64(), rand64(), rand64());
      send_record(SIDE_B, kept_file, kept_offset, rand64(), ~kept_hash);
      send_record(SIDE_A, pick_file(), rand64(), rand64(), rand64());
      send_record(SIDE_A, pick_file(), rand64(), rand64(), rand64());
      kept_file   = held_file[1];
      kept_offset = held_offset[1];
      kept_hash   = held_hash[1];
      send_record(SIDE_A, kept_file, kept_offset, rand64(), kept_hash);
      drain_all();
   endtask

   task automatic test_matching_traffic();
      run_mixed_traffic(600, 24, 15, 10);
   endtask

   task automatic test_near_full_traffic();
      fill_table(CAPACITY - 6);
      run_mixed_traffic(150, 8, 45, 5);
   endtask

   // result side stall patterns
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             run_left = 0;
   logic           run_stall = 1'b0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(40, 300);
      end
      mode_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (run_left == 0) begin
               run_left  = $urandom_range(1, 12);
               run_stall = ~run_stall;
            end
            run_left--;
            rsp_stall <= run_stall;
         end
      endcase
   end

   task automatic note_mismatch(string what, diff_report_type want, diff_report_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t %s", $realtime, what);
         $display("  expected status %0d file %h offset %h length %h a %h b %h last %b",
                  want.status, want.file, want.offset, want.length, want.hash_a,
                  want.hash_b, want.last);
         $display("  actual   status %0d file %h offset %h length %h a %h b %h last %b",
                  got.status, got.file, got.offset, got.length, got.hash_a,
                  got.hash_b, got.last);
      end
   endtask

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      diff_report_type got;
      diff_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_out_file_id, rsp_out_offset, rsp_out_length,
                rsp_hash_a, rsp_hash_b, rsp_last_leftover};
         if (pending_reports.size() == 0) begin
            note_mismatch("result transaction with none expected", '0, got);
         end else begin
            want = pending_reports.pop_front();
            if (got != want) note_mismatch("result transaction mismatch", want, got);
         end
      end
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int waited;
      for (int i = 0; i < CAPACITY; i++) held_valid[i] = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_full_table();
      test_matching_traffic();
      test_near_full_traffic();

      @(negedge clock);
      req_valid = 1'b0;
      waited = 0;
      while (pending_reports.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_reports.size() != 0) begin
         mismatch_count += pending_reports.size();
         $display("%0d result transactions never arrived", pending_reports.size());
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
sv/krdt_pkg.sv
sv/krdt_cell.sv
sv/krdt_chain.sv
sv/keyed_record_diff_table_unit.sv
test/keyed_record_diff_table_unit_test.sv
